/* sv/csc_pkg.sv */
// shared types, widths and helpers for the circle pair collision block
// no dependencies
package csc_pkg;

  localparam int POS_W  = 24;
  localparam int RAD_W  = 16;
  localparam int DIFF_W = POS_W + 1;
  localparam int SUM_W  = RAD_W + 1;   // radius sum, also the widest distance on a hit
  localparam int SQ_W   = 2 * DIFF_W - 1;
  localparam int VN_W   = 28;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] vx;
    logic signed [POS_W-1:0] vy;
    logic        [RAD_W-1:0] r;
  } circ_t;

  typedef struct packed {
    circ_t                    a;
    circ_t                    b;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic        [SUM_W-1:0]  minsum;
    logic                     hit;
  } fwd_t;

  typedef struct packed {
    fwd_t             f;
    logic [SUM_W-1:0] dlen;
  } dsb_t;

  // scale by 2^-s (shift right by s), truncated toward zero
  function automatic logic signed [63:0] shr_tz(input logic signed [63:0] v, input int s);
    logic [63:0] mag;
    logic [63:0] sh;
    mag = v[63] ? 64'(-v) : 64'(v);
    sh  = mag >> s;
    return v[63] ? -$signed(sh) : $signed(sh);
  endfunction

  function automatic logic signed [POS_W-1:0] sat24(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd8388607;
    lo = -64'sd8388608;
    if (v > hi) return hi[POS_W-1:0];
    if (v < lo) return lo[POS_W-1:0];
    return v[POS_W-1:0];
  endfunction

endpackage

/* sv/csc_ifs.sv */
// valid/ready channel interfaces for circle pairs and their results
// no dependencies
interface csc_in_if;
  logic              valid;
  logic              ready;
  logic signed [23:0] first_x;
  logic signed [23:0] first_y;
  logic signed [23:0] first_vel_x;
  logic signed [23:0] first_vel_y;
  logic        [15:0] first_radius;
  logic signed [23:0] second_x;
  logic signed [23:0] second_y;
  logic signed [23:0] second_vel_x;
  logic signed [23:0] second_vel_y;
  logic        [15:0] second_radius;
  modport source (output valid, first_x, first_y, first_vel_x, first_vel_y, first_radius,
                  second_x, second_y, second_vel_x, second_vel_y, second_radius,
                  input ready);
  modport sink (input valid, first_x, first_y, first_vel_x, first_vel_y, first_radius,
                second_x, second_y, second_vel_x, second_vel_y, second_radius,
                output ready);
endinterface

interface csc_out_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [23:0] new_first_x;
  logic signed [23:0] new_first_y;
  logic signed [23:0] new_first_vel_x;
  logic signed [23:0] new_first_vel_y;
  logic signed [23:0] new_second_x;
  logic signed [23:0] new_second_y;
  logic signed [23:0] new_second_vel_x;
  logic signed [23:0] new_second_vel_y;
  modport source (output valid, hit, new_first_x, new_first_y, new_first_vel_x,
                  new_first_vel_y, new_second_x, new_second_y, new_second_vel_x,
                  new_second_vel_y, input ready);
  modport sink (input valid, hit, new_first_x, new_first_y, new_first_vel_x,
                new_first_vel_y, new_second_x, new_second_y, new_second_vel_x,
                new_second_vel_y, output ready);
endinterface

/* sv/circle_pair_collision.sv */
// Circle pair collision test and equal-mass elastic response.
// Input channel in_ch carries one circle pair per item (centers, velocities,
// radii, fixed point with FRACTION_BITS fraction bits); output channel out_ch
// carries one result item per input item: the hit flag and the corrected
// centers and velocities, saturated to 24 bits.
// Both channels are valid/ready; an item moves when valid and ready are high.
// The pipeline has three front stages (differences, squares, compare),
// 17 square root stages, one divider stage per normal bit and five
// response stages.
// Throughput is one item per cycle: every stage advances together, and the
// whole pipeline holds while the output item waits, so in_ch.ready is low
// only when a result is held by a stalled receiver. Nothing is lost or repeated.
// Reset clears all valid bits; the pipeline comes out of reset empty.
// depends on csc_pkg, csc_ifs, csc_sqrt, csc_div, csc_resolve
module circle_pair_collision
  import csc_pkg::*;
#(
  parameter int FRACTION_BITS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  csc_in_if.sink     in_ch,
  csc_out_if.source  out_ch
);

  localparam int NB = 2 * FRACTION_BITS;

  logic en;
  assign en = !(out_ch.valid && !out_ch.ready);
  assign in_ch.ready = en;

  logic                     v1_r, v2_r, v3_r;
  fwd_t                     f1_r, f2_r, f3_r;
  fwd_t                     f3_nxt;
  logic [SQ_W-1:0]          sqx2_r, sqy2_r;
  logic [2*SUM_W-1:0]       msq2_r;
  logic [2*SUM_W-1:0]       rad3_r;
  logic [SQ_W:0]            d2;
  circ_t                    ca, cb;

  assign ca = '{x: in_ch.first_x, y: in_ch.first_y, vx: in_ch.first_vel_x,
                vy: in_ch.first_vel_y, r: in_ch.first_radius};
  assign cb = '{x: in_ch.second_x, y: in_ch.second_y, vx: in_ch.second_vel_x,
                vy: in_ch.second_vel_y, r: in_ch.second_radius};
  assign d2 = (SQ_W+1)'(sqx2_r) + (SQ_W+1)'(sqy2_r);

  always_comb begin
    f3_nxt     = f2_r;
    // distance below radius sum exactly when d2 is below its square
    f3_nxt.hit = d2 < (SQ_W+1)'(msq2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r.a      <= ca;
      f1_r.b      <= cb;
      f1_r.dx     <= DIFF_W'(cb.x) - DIFF_W'(ca.x);
      f1_r.dy     <= DIFF_W'(cb.y) - DIFF_W'(ca.y);
      f1_r.minsum <= SUM_W'(ca.r) + SUM_W'(cb.r);
      f1_r.hit    <= 1'b0;

      f2_r   <= f1_r;
      sqx2_r <= SQ_W'(f1_r.dx * f1_r.dx);
      sqy2_r <= SQ_W'(f1_r.dy * f1_r.dy);
      msq2_r <= f1_r.minsum * f1_r.minsum;

      f3_r   <= f3_nxt;
      rad3_r <= d2[2*SUM_W-1:0];
    end
  end

  logic             sq_v;
  logic [SUM_W-1:0] sq_root;
  fwd_t             sq_f;

  csc_sqrt #(.W(SUM_W), .SB($bits(fwd_t))) u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v3_r), .in_rad(rad3_r), .in_sb(f3_r),
    .out_valid(sq_v), .out_root(sq_root), .out_sb(sq_f)
  );

  logic [DIFF_W-1:0] adx, ady;
  dsb_t              dv_in, dv_out;
  logic              dv_v;
  logic [NB:0]       q_a, q_b;

  assign adx   = sq_f.dx[DIFF_W-1] ? DIFF_W'(-sq_f.dx) : DIFF_W'(sq_f.dx);
  assign ady   = sq_f.dy[DIFF_W-1] ? DIFF_W'(-sq_f.dy) : DIFF_W'(sq_f.dy);
  assign dv_in = '{f: sq_f, dlen: sq_root};

  // on a hit both offsets are no larger than the distance
  csc_div #(.NB(NB), .DW(SUM_W), .SB($bits(dsb_t))) u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(sq_v), .in_num_a(adx[SUM_W-1:0]), .in_num_b(ady[SUM_W-1:0]),
    .in_den(sq_root), .in_sb(dv_in),
    .out_valid(dv_v), .out_q_a(q_a), .out_q_b(q_b), .out_sb(dv_out)
  );

  circ_t ra, rb;

  csc_resolve #(.NB(NB)) u_res (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(dv_v), .in_q_a(q_a), .in_q_b(q_b), .in_sb(dv_out),
    .out_valid(out_ch.valid), .out_hit(out_ch.hit), .out_a(ra), .out_b(rb)
  );

  assign out_ch.new_first_x      = ra.x;
  assign out_ch.new_first_y      = ra.y;
  assign out_ch.new_first_vel_x  = ra.vx;
  assign out_ch.new_first_vel_y  = ra.vy;
  assign out_ch.new_second_x     = rb.x;
  assign out_ch.new_second_y     = rb.y;
  assign out_ch.new_second_vel_x = rb.vx;
  assign out_ch.new_second_vel_y = rb.vy;

endmodule

/* sv/csc_sqrt.sv */
// pipelined integer square root, one result bit per stage
// depends on nothing; sideband rides along unchanged
module csc_sqrt #(
  parameter int W  = 17,
  parameter int SB = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [2*W-1:0] in_rad,
  input  logic [SB-1:0] in_sb,
  output logic          out_valid,
  output logic [W-1:0]  out_root,
  output logic [SB-1:0] out_sb
);

  logic            v_r    [0:W-1];
  logic [W+1:0]    rem_r  [0:W-1];
  logic [W-1:0]    root_r [0:W-1];
  logic [2*W-1:0]  x_r    [0:W-1];
  logic [SB-1:0]   sb_r   [0:W-1];

  for (genvar i = 0; i < W; i++) begin : g_st
    logic           pv;
    logic [W+1:0]   prem;
    logic [W-1:0]   proot;
    logic [2*W-1:0] px;
    logic [SB-1:0]  psb;
    logic [W+3:0]   cur;
    logic [W+3:0]   trial;
    if (i == 0) begin : g_first
      assign pv = in_valid;
      assign prem = '0;
      assign proot = '0;
      assign px = in_rad;
      assign psb = in_sb;
    end else begin : g_next
      assign pv = v_r[i-1];
      assign prem = rem_r[i-1];
      assign proot = root_r[i-1];
      assign px = x_r[i-1];
      assign psb = sb_r[i-1];
    end
    assign cur   = {prem, px[2*W-1 -: 2]};
    assign trial = {2'b00, proot, 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (cur >= trial) begin
          rem_r[i]  <= (W+2)'(cur - trial);
          root_r[i] <= {proot[W-2:0], 1'b1};
        end else begin
          rem_r[i]  <= cur[W+1:0];
          root_r[i] <= {proot[W-2:0], 1'b0};
        end
        x_r[i]  <= {px[2*W-3:0], 2'b00};
        sb_r[i] <= psb;
      end
    end
  end

  assign out_valid = v_r[W-1];
  assign out_root  = root_r[W-1];
  assign out_sb    = sb_r[W-1];

endmodule

/* sv/csc_div.sv */
// pipelined restoring divider for the two normal components, shared divisor
// one quotient bit per stage; depends on nothing
module csc_div #(
  parameter int NB = 16,
  parameter int DW = 17,
  parameter int SB = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] in_num_a,
  input  logic [DW-1:0] in_num_b,
  input  logic [DW-1:0] in_den,
  input  logic [SB-1:0] in_sb,
  output logic          out_valid,
  output logic [NB:0]   out_q_a,
  output logic [NB:0]   out_q_b,
  output logic [SB-1:0] out_sb
);

  localparam int RW = DW + NB + 1;
  localparam int NS = NB + 1;

  logic          v_r   [0:NS-1];
  logic [RW-1:0] ra_r  [0:NS-1];
  logic [RW-1:0] rb_r  [0:NS-1];
  logic [NB:0]   qa_r  [0:NS-1];
  logic [NB:0]   qb_r  [0:NS-1];
  logic [DW-1:0] den_r [0:NS-1];
  logic [SB-1:0] sb_r  [0:NS-1];

  for (genvar i = 0; i < NS; i++) begin : g_st
    logic          pv;
    logic [RW-1:0] pra;
    logic [RW-1:0] prb;
    logic [NB:0]   pqa;
    logic [NB:0]   pqb;
    logic [DW-1:0] pden;
    logic [SB-1:0] psb;
    logic [RW-1:0] trial;
    if (i == 0) begin : g_first
      assign pv = in_valid;
      assign pra = RW'({in_num_a, {NB{1'b0}}});
      assign prb = RW'({in_num_b, {NB{1'b0}}});
      assign pqa = '0;
      assign pqb = '0;
      assign pden = in_den;
      assign psb = in_sb;
    end else begin : g_next
      assign pv = v_r[i-1];
      assign pra = ra_r[i-1];
      assign prb = rb_r[i-1];
      assign pqa = qa_r[i-1];
      assign pqb = qb_r[i-1];
      assign pden = den_r[i-1];
      assign psb = sb_r[i-1];
    end
    assign trial = RW'(pden) << (NB - i);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (pra >= trial) begin
          ra_r[i] <= pra - trial;
          qa_r[i] <= pqa | ((NB+1)'(1) << (NB - i));
        end else begin
          ra_r[i] <= pra;
          qa_r[i] <= pqa;
        end
        if (prb >= trial) begin
          rb_r[i] <= prb - trial;
          qb_r[i] <= pqb | ((NB+1)'(1) << (NB - i));
        end else begin
          rb_r[i] <= prb;
          qb_r[i] <= pqb;
        end
        den_r[i] <= pden;
        sb_r[i]  <= psb;
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_q_a   = qa_r[NS-1];
  assign out_q_b   = qb_r[NS-1];
  assign out_sb    = sb_r[NS-1];

endmodule

/* sv/csc_resolve.sv */
// collision response: push-out and velocity exchange along the normal, five stages
// depends on csc_pkg
module csc_resolve
  import csc_pkg::*;
#(
  parameter int NB = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [NB:0] in_q_a,
  input  logic [NB:0] in_q_b,
  input  dsb_t        in_sb,
  output logic        out_valid,
  output logic        out_hit,
  output circ_t       out_a,
  output circ_t       out_b
);

  localparam int NW = NB + 2;

  // stage 1: signed normal, overlap, relative velocity
  logic                     v1_r, v2_r, v3_r, v4_r, v5_r;
  logic signed [NW-1:0]     nx1_r, ny1_r;
  logic signed [SUM_W:0]    ov1_r;
  logic signed [DIFF_W-1:0] rvx1_r, rvy1_r;
  logic                     skip1_r, hit1_r;
  circ_t                    a1_r, b1_r;

  // stage 2: products
  logic signed [NW+SUM_W:0]  mpx2_r, mpy2_r;
  logic signed [NW+DIFF_W-1:0] vpx2_r, vpy2_r;
  logic signed [NW-1:0]      nx2_r, ny2_r;
  logic                      skip2_r, hit2_r;
  circ_t                     a2_r, b2_r;

  // stage 3: positions, normal speed
  logic signed [VN_W-1:0] vn3_r;
  logic                   dov3_r, hit3_r;
  logic signed [NW-1:0]   nx3_r, ny3_r;
  circ_t                  a3_r, b3_r;
  circ_t                  a3_nxt, b3_nxt;

  // stage 4: velocity products
  logic signed [VN_W+NW-1:0] epx4_r, epy4_r;
  logic                      dov4_r, hit4_r;
  circ_t                     a4_r, b4_r;

  circ_t a5_r, b5_r;
  circ_t a5_nxt, b5_nxt;
  logic  hit5_r;

  logic signed [63:0] mx, my, vfull, vn, ex, ey;

  always_comb begin
    mx    = skip2_r ? 64'sd0 : shr_tz(64'(mpx2_r), NB + 1);
    my    = skip2_r ? 64'sd0 : shr_tz(64'(mpy2_r), NB + 1);
    vfull = 64'(vpx2_r) + 64'(vpy2_r);
    vn    = shr_tz(vfull, NB);
    ex    = dov4_r ? shr_tz(64'(epx4_r), NB) : 64'sd0;
    ey    = dov4_r ? shr_tz(64'(epy4_r), NB) : 64'sd0;

    a3_nxt   = a2_r;
    b3_nxt   = b2_r;
    a3_nxt.x = sat24(64'(a2_r.x) - mx);
    a3_nxt.y = sat24(64'(a2_r.y) - my);
    b3_nxt.x = sat24(64'(b2_r.x) + mx);
    b3_nxt.y = sat24(64'(b2_r.y) + my);

    a5_nxt    = a4_r;
    b5_nxt    = b4_r;
    a5_nxt.vx = sat24(64'(a4_r.vx) + ex);
    a5_nxt.vy = sat24(64'(a4_r.vy) + ey);
    b5_nxt.vx = sat24(64'(b4_r.vx) - ex);
    b5_nxt.vy = sat24(64'(b4_r.vy) - ey);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx1_r   <= in_sb.f.dx[DIFF_W-1] ? -$signed({1'b0, in_q_a}) : $signed({1'b0, in_q_a});
      ny1_r   <= in_sb.f.dy[DIFF_W-1] ? -$signed({1'b0, in_q_b}) : $signed({1'b0, in_q_b});
      ov1_r   <= $signed({1'b0, SUM_W'(in_sb.f.minsum - in_sb.dlen)});
      rvx1_r  <= DIFF_W'(in_sb.f.b.vx) - DIFF_W'(in_sb.f.a.vx);
      rvy1_r  <= DIFF_W'(in_sb.f.b.vy) - DIFF_W'(in_sb.f.a.vy);
      skip1_r <= !in_sb.f.hit || (in_sb.dlen == '0);
      hit1_r  <= in_sb.f.hit;
      a1_r    <= in_sb.f.a;
      b1_r    <= in_sb.f.b;

      mpx2_r  <= nx1_r * ov1_r;
      mpy2_r  <= ny1_r * ov1_r;
      vpx2_r  <= rvx1_r * nx1_r;
      vpy2_r  <= rvy1_r * ny1_r;
      nx2_r   <= nx1_r;
      ny2_r   <= ny1_r;
      skip2_r <= skip1_r;
      hit2_r  <= hit1_r;
      a2_r    <= a1_r;
      b2_r    <= b1_r;

      vn3_r  <= vn[VN_W-1:0];
      dov3_r <= !skip2_r && (vfull <= 64'sd0);
      nx3_r  <= nx2_r;
      ny3_r  <= ny2_r;
      hit3_r <= hit2_r;
      a3_r   <= a3_nxt;
      b3_r   <= b3_nxt;

      epx4_r <= vn3_r * nx3_r;
      epy4_r <= vn3_r * ny3_r;
      dov4_r <= dov3_r;
      hit4_r <= hit3_r;
      a4_r   <= a3_r;
      b4_r   <= b3_r;

      hit5_r <= hit4_r;
      a5_r   <= a5_nxt;
      b5_r   <= b5_nxt;
    end
  end

  assign out_valid = v5_r;
  assign out_hit   = hit5_r;
  assign out_a     = a5_r;
  assign out_b     = b5_r;

endmodule

/* sv/csc_checker.sv */
// port-level checks for circle_pair_collision, bound to the top level
// depends on circle_pair_collision
module csc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_hit,
  input logic signed [23:0] out_first_x
);

  // input stalls only behind a held result item
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == !(out_valid && !out_ready))
    else $error("in ready does not follow output stall");

  a_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result item right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit) && $stable(out_first_x))
    else $error("stalled result item changed");

  // handshake lines are always driven once out of reset
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown(out_valid) && !$isunknown(in_ready))
    else $error("unknown handshake");

endmodule

bind circle_pair_collision csc_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_hit(out_ch.hit), .out_first_x(out_ch.new_first_x)
);

/* sim/testbench.sv */
// testbench for circle_pair_collision: directed and random circle pairs,
// with an in-house predictor of the collision response and a result checker
// depends on csc_pkg, csc_ifs and the circle_pair_collision rtl
module testbench;
  import csc_pkg::*;

  localparam int FRAC      = 8;
  localparam int NRM       = 2 * FRAC;
  localparam int LATENCY   = 2 * FRAC + 26;
  localparam int RAND_ITEMS = 1100;

  typedef struct packed {
    logic                    hit;
    logic signed [POS_W-1:0] ax, ay, avx, avy, bx, by, bvx, bvy;
  } collision_t;

  logic clk;
  logic rst_n;
  csc_in_if  in_ch();
  csc_out_if out_ch();

  circle_pair_collision #(.FRACTION_BITS(FRAC)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  collision_t expected_q[$];
  int errors;
  bit quiet_in;
  bit quiet_out;
  bit hold_out;
  bit done;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic signed [63:0] trunc_shift(logic signed [63:0] v, int s);
    logic [63:0] m;
    m = v < 0 ? 64'(-v) : 64'(v);
    m = m >> s;
    return v < 0 ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [POS_W-1:0] clamp24(logic signed [63:0] v);
    if (v > 64'sd8388607) return 24'sh7fffff;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[POS_W-1:0];
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic collision_t resolve_pair(circ_t a, circ_t b);
    collision_t r;
    logic signed [63:0] ax, ay, avx, avy, bx, by, bvx, bvy, dx, dy;
    logic signed [63:0] nx, ny, ov, mx, my, vfull, vn, ex, ey;
    logic [63:0] d2, dlen, minsum;
    ax = a.x; ay = a.y; avx = a.vx; avy = a.vy;
    bx = b.x; by = b.y; bvx = b.vx; bvy = b.vy;
    dx = bx - ax;
    dy = by - ay;
    d2 = 64'(dx * dx) + 64'(dy * dy);
    dlen = int_sqrt(d2);
    minsum = 64'(a.r) + 64'(b.r);
    r.hit = dlen < minsum;
    if (r.hit && dlen != 0) begin
      // normal in NRM fraction bits, quotient truncated toward zero
      nx = $signed(((dx < 0 ? 64'(-dx) : 64'(dx)) << NRM) / dlen);
      if (dx < 0) nx = -nx;
      ny = $signed(((dy < 0 ? 64'(-dy) : 64'(dy)) << NRM) / dlen);
      if (dy < 0) ny = -ny;
      ov = $signed(minsum - dlen);
      mx = trunc_shift(nx * ov, NRM + 1);
      my = trunc_shift(ny * ov, NRM + 1);
      ax -= mx; ay -= my; bx += mx; by += my;
      vfull = (bvx - avx) * nx + (bvy - avy) * ny;
      if (vfull <= 0) begin
        vn = trunc_shift(vfull, NRM);
        ex = trunc_shift(vn * nx, NRM);
        ey = trunc_shift(vn * ny, NRM);
        avx += ex; avy += ey; bvx -= ex; bvy -= ey;
      end
    end
    r.ax = clamp24(ax); r.ay = clamp24(ay); r.avx = clamp24(avx); r.avy = clamp24(avy);
    r.bx = clamp24(bx); r.by = clamp24(by); r.bvx = clamp24(bvx); r.bvy = clamp24(bvy);
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  task automatic send_pair(circ_t a, circ_t b);
    in_ch.valid <= 1'b1;
    in_ch.first_x <= a.x; in_ch.first_y <= a.y;
    in_ch.first_vel_x <= a.vx; in_ch.first_vel_y <= a.vy; in_ch.first_radius <= a.r;
    in_ch.second_x <= b.x; in_ch.second_y <= b.y;
    in_ch.second_vel_x <= b.vx; in_ch.second_vel_y <= b.vy; in_ch.second_radius <= b.r;
    do @(posedge clk); while (!in_ch.ready);
    expected_q = {expected_q, resolve_pair(a, b)};
    // random gap after the item; valid stays up otherwise
    while (!quiet_in && $urandom_range(99) < 9) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // output side: random stalls, long hold when asked
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= !hold_out && (quiet_out || $urandom_range(99) >= 9);
  end

  always @(posedge clk) begin
    collision_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        report("unexpected item", 0, 0);
      end else begin
        e = expected_q.pop_front();
        if (out_ch.hit !== e.hit) report("hit", out_ch.hit, e.hit);
        if (out_ch.new_first_x !== e.ax) report("new_first_x", out_ch.new_first_x, e.ax);
        if (out_ch.new_first_y !== e.ay) report("new_first_y", out_ch.new_first_y, e.ay);
        if (out_ch.new_first_vel_x !== e.avx)
          report("new_first_vel_x", out_ch.new_first_vel_x, e.avx);
        if (out_ch.new_first_vel_y !== e.avy)
          report("new_first_vel_y", out_ch.new_first_vel_y, e.avy);
        if (out_ch.new_second_x !== e.bx) report("new_second_x", out_ch.new_second_x, e.bx);
        if (out_ch.new_second_y !== e.by) report("new_second_y", out_ch.new_second_y, e.by);
        if (out_ch.new_second_vel_x !== e.bvx)
          report("new_second_vel_x", out_ch.new_second_vel_x, e.bvx);
        if (out_ch.new_second_vel_y !== e.bvy)
          report("new_second_vel_y", out_ch.new_second_vel_y, e.bvy);
      end
    end
  end

  function automatic circ_t make_circle(int x, int y, int vx, int vy, int r);
    circ_t c;
    c.x = POS_W'(x); c.y = POS_W'(y); c.vx = POS_W'(vx); c.vy = POS_W'(vy);
    c.r = RAD_W'(r);
    return c;
  endfunction

  function automatic circ_t any_circle();
    circ_t c;
    c.x = POS_W'($urandom); c.y = POS_W'($urandom);
    c.vx = POS_W'($urandom); c.vy = POS_W'($urandom);
    c.r = RAD_W'($urandom);
    return c;
  endfunction

  // second circle close to the first so that most pairs overlap
  function automatic circ_t near_circle(circ_t a, int span);
    circ_t c;
    c = any_circle();
    c.x = POS_W'(a.x + $signed($urandom_range(2 * span)) - span);
    c.y = POS_W'(a.y + $signed($urandom_range(2 * span)) - span);
    if ($urandom_range(3) == 0) begin
      c.vx = POS_W'(a.vx + $signed($urandom_range(4000)) - 2000);
      c.vy = POS_W'(a.vy + $signed($urandom_range(4000)) - 2000);
    end
    return c;
  endfunction

  task automatic test_directed();
    circ_t a;
    // clear miss, touching, overlap approaching and separating
    send_pair(make_circle(0, 0, 256, 0, 256), make_circle(5000, 0, -256, 0, 256));
    send_pair(make_circle(0, 0, 256, 0, 256), make_circle(512, 0, -256, 0, 256));
    send_pair(make_circle(0, 0, 256, 0, 256), make_circle(300, 0, -256, 0, 256));
    send_pair(make_circle(0, 0, -256, 0, 256), make_circle(300, 0, 256, 0, 256));
    send_pair(make_circle(0, 0, 100, 50, 400), make_circle(200, 300, -70, -90, 500));
    // zero radii, coincident centers
    send_pair(make_circle(0, 0, 5, 5, 0), make_circle(0, 0, 9, 9, 0));
    send_pair(make_circle(77, -77, 5, 5, 1), make_circle(77, -77, -9, 9, 0));
    send_pair(make_circle(-8388608, -8388608, 8388607, -8388608, 65535),
              make_circle(-8388608, -8388608, -8388608, 8388607, 65535));
    // saturation at the corners of the range
    send_pair(make_circle(8388607, 8388607, -8388608, -8388608, 65535),
              make_circle(8388600, 8388600, 8388607, 8388607, 65535));
    send_pair(make_circle(-8388608, -8388608, 8388607, 8388607, 65535),
              make_circle(-8388600, -8388600, -8388608, -8388608, 65535));
    send_pair(make_circle(-8388608, 0, 0, 0, 65535), make_circle(8388607, 0, 0, 0, 65535));
    send_pair(make_circle(0, -8388608, 0, 0, 0), make_circle(0, 8388607, 0, 0, 0));
    send_pair(make_circle(8388607, 8388607, 8388607, 8388607, 65535),
              make_circle(-8388608, -8388608, -8388608, -8388608, 65535));
    send_pair(make_circle(0, 0, 0, 0, 65535), make_circle(1, 1, 0, 0, 65535));
    send_pair(make_circle(10, 0, 8388607, 0, 65535), make_circle(0, 0, -8388608, 0, 65535));
    send_pair(make_circle(0, 0, 0, 0, 100), make_circle(0, 60000, 0, -8388608, 65535));
    for (int i = 0; i < 4; i++) begin
      a = any_circle();
      send_pair(a, near_circle(a, 200000));
    end
  endtask

  task automatic test_random(int count);
    circ_t a, b;
    for (int i = 0; i < count; i++) begin
      a = any_circle();
      case ($urandom_range(9))
        0, 1: b = any_circle();
        2:    b = near_circle(a, 300);
        default: b = near_circle(a, 90000);
      endcase
      send_pair(a, b);
    end
  endtask

  task automatic test_backpressure();
    circ_t a;
    fork
      begin
        hold_out = 1'b1;
        repeat (3 * LATENCY) @(posedge clk);
        hold_out = 1'b0;
      end
      begin
        quiet_in = 1'b1;
        for (int i = 0; i < 150; i++) begin
          a = any_circle();
          send_pair(a, near_circle(a, 50000));
        end
        quiet_in = 1'b0;
      end
    join
  endtask

  task automatic test_no_idle();
    quiet_in = 1'b1;
    quiet_out = 1'b1;
    test_random(200);
    quiet_in = 1'b0;
    quiet_out = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.first_x = '0; in_ch.first_y = '0; in_ch.first_vel_x = '0;
    in_ch.first_vel_y = '0; in_ch.first_radius = '0;
    in_ch.second_x = '0; in_ch.second_y = '0; in_ch.second_vel_x = '0;
    in_ch.second_vel_y = '0; in_ch.second_radius = '0;
    errors = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(RAND_ITEMS - 550);
    test_backpressure();
    test_no_idle();
    test_random(200);
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    done = 1'b1;
    if (errors == 0) $display("[circle_pair_collision] OK");
    else $display("[circle_pair_collision] ERROR");
    $finish;
  end

  initial begin
    #400000;
    if (!done) begin
      $display("[circle_pair_collision] ERROR");
      $finish;
    end
  end
endmodule
